// ===== hw/rtl/sorm_pkg.sv =====
// Package for the spiral order matrix reader.
// Holds the command, direction and status codes and the payload structs.
// Depends on nothing; sorm_walk and the top level use it.
`default_nettype none

package sorm_pkg;

    localparam int REG_WIDTH = 7;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int FIELD_WIDTH = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COL_COUNT = 2'd1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EMIT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef struct packed {
        logic                          command;
        logic signed [FIELD_WIDTH-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] out_value;
        logic                          last_element;
        logic                          status;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic err;
        logic last;
    } resp_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorm_store.sv =====
// Matrix element memory of the spiral order matrix reader.
// One write port and one read port with registered read data.
// Depends on nothing outside this file.
`default_nettype none

module sorm_store #(
    parameter int DEPTH = 4096,
    parameter int ADDR_WIDTH = 12,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_WIDTH-1:0] wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_WIDTH-1:0] rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorm_walk.sv =====
// Load sequencer and spiral walk of the spiral order matrix reader.
// Holds the size registers, the row-major load position and the spiral position.
// Depends on sorm_pkg.
`default_nettype none

module sorm_walk #(
    parameter int MAX_DIM = 64,
    parameter int COORD_WIDTH = 6,
    parameter int ADDR_WIDTH = 12
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_write,
    input  wire logic [sorm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [sorm_pkg::REG_WIDTH-1:0]          cfg_data,
    input  wire logic                                    cmd_valid,
    input  wire logic                                    cmd,
    output logic                                         wr_en,
    output logic      [ADDR_WIDTH-1:0]                   wr_addr,
    output logic                                         rd_en,
    output logic      [ADDR_WIDTH-1:0]                   rd_addr,
    output sorm_pkg::resp_ctrl_t                         resp
);

    localparam int DIM_WIDTH = $clog2(MAX_DIM + 1);
    localparam int COUNT_WIDTH = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam logic [ADDR_WIDTH-1:0] ROW_STRIDE = ADDR_WIDTH'(MAX_DIM);

    function automatic logic [DIM_WIDTH-1:0] dim_of(input logic [sorm_pkg::REG_WIDTH-1:0] r);
        logic [DIM_WIDTH-1:0] d;
        if (r == '0)
        begin
            d = DIM_WIDTH'(1);
        end
        else if (32'(r) > MAX_DIM)
        begin
            d = DIM_WIDTH'(MAX_DIM);
        end
        else
        begin
            d = DIM_WIDTH'(r);
        end
        return d;
    endfunction

    function automatic logic [ADDR_WIDTH-1:0] addr_of(input logic [COORD_WIDTH-1:0] r,
                                                      input logic [COORD_WIDTH-1:0] c);
        return ADDR_WIDTH'(r) * ROW_STRIDE + ADDR_WIDTH'(c);
    endfunction

    logic [sorm_pkg::REG_WIDTH-1:0] row_count_reg, col_count_reg;
    logic [COORD_WIDTH-1:0]         load_row_reg, load_row_next;
    logic [COORD_WIDTH-1:0]         load_col_reg, load_col_next;
    logic                           load_done_reg, load_done_next;
    logic [COORD_WIDTH-1:0]         pos_r_reg, pos_r_next, pos_c_reg, pos_c_next;
    logic [COORD_WIDTH-1:0]         top_reg, top_next, bottom_reg, bottom_next;
    logic [COORD_WIDTH-1:0]         left_reg, left_next, right_reg, right_next;
    sorm_pkg::dir_t                 dir_reg, dir_next;
    logic [COUNT_WIDTH-1:0]         emitted_reg, emitted_next;
    sorm_pkg::resp_ctrl_t           resp_reg, resp_next;

    logic [DIM_WIDTH-1:0]   rows, cols;
    logic [COUNT_WIDTH-1:0] total;
    logic                   restart;
    logic                   is_load, is_emit, emit_err, emit_ok;

    assign rows = dim_of(row_count_reg);
    assign cols = dim_of(col_count_reg);
    assign total = COUNT_WIDTH'(rows) * COUNT_WIDTH'(cols);
    assign restart = cfg_write && (cfg_index == sorm_pkg::CFG_ROW_COUNT ||
                                   cfg_index == sorm_pkg::CFG_COL_COUNT);

    assign is_load = cmd_valid && (cmd == sorm_pkg::CMD_LOAD);
    assign is_emit = cmd_valid && (cmd == sorm_pkg::CMD_EMIT);
    assign emit_err = !load_done_reg || (emitted_reg == total);
    assign emit_ok = is_emit && !emit_err;

    assign wr_en = is_load && !load_done_reg;
    assign wr_addr = addr_of(load_row_reg, load_col_reg);
    assign rd_en = emit_ok;
    assign rd_addr = addr_of(pos_r_reg, pos_c_reg);
    assign resp = resp_reg;

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        load_done_next = load_done_reg;
        pos_r_next = pos_r_reg;
        pos_c_next = pos_c_reg;
        top_next = top_reg;
        bottom_next = bottom_reg;
        left_next = left_reg;
        right_next = right_reg;
        dir_next = dir_reg;
        emitted_next = emitted_reg;

        resp_next.valid = is_emit;
        resp_next.err = emit_err;
        resp_next.last = !emit_err && (emitted_reg + COUNT_WIDTH'(1) == total);

        if (wr_en)
        begin
            if (DIM_WIDTH'(load_col_reg) == cols - DIM_WIDTH'(1))
            begin
                load_col_next = '0;
                if (DIM_WIDTH'(load_row_reg) == rows - DIM_WIDTH'(1))
                begin
                    // The matrix is full: set up the outer ring of the walk.
                    load_done_next = 1'b1;
                    pos_r_next = '0;
                    pos_c_next = '0;
                    top_next = '0;
                    left_next = '0;
                    bottom_next = COORD_WIDTH'(rows - DIM_WIDTH'(1));
                    right_next = COORD_WIDTH'(cols - DIM_WIDTH'(1));
                    dir_next = sorm_pkg::DIR_RIGHT;
                    emitted_next = '0;
                end
                else
                begin
                    load_row_next = load_row_reg + COORD_WIDTH'(1);
                end
            end
            else
            begin
                load_col_next = load_col_reg + COORD_WIDTH'(1);
            end
        end

        if (emit_ok)
        begin
            emitted_next = emitted_reg + COUNT_WIDTH'(1);
            case (dir_reg)
                sorm_pkg::DIR_RIGHT:
                begin
                    if (pos_c_reg < right_reg)
                    begin
                        pos_c_next = pos_c_reg + COORD_WIDTH'(1);
                    end
                    else
                    begin
                        top_next = top_reg + COORD_WIDTH'(1);
                        pos_r_next = pos_r_reg + COORD_WIDTH'(1);
                        dir_next = sorm_pkg::DIR_DOWN;
                    end
                end
                sorm_pkg::DIR_DOWN:
                begin
                    if (pos_r_reg < bottom_reg)
                    begin
                        pos_r_next = pos_r_reg + COORD_WIDTH'(1);
                    end
                    else
                    begin
                        right_next = right_reg - COORD_WIDTH'(1);
                        pos_c_next = pos_c_reg - COORD_WIDTH'(1);
                        dir_next = sorm_pkg::DIR_LEFT;
                    end
                end
                sorm_pkg::DIR_LEFT:
                begin
                    if (pos_c_reg > left_reg)
                    begin
                        pos_c_next = pos_c_reg - COORD_WIDTH'(1);
                    end
                    else
                    begin
                        bottom_next = bottom_reg - COORD_WIDTH'(1);
                        pos_r_next = pos_r_reg - COORD_WIDTH'(1);
                        dir_next = sorm_pkg::DIR_UP;
                    end
                end
                default:
                begin
                    if (pos_r_reg > top_reg)
                    begin
                        pos_r_next = pos_r_reg - COORD_WIDTH'(1);
                    end
                    else
                    begin
                        left_next = left_reg + COORD_WIDTH'(1);
                        pos_c_next = pos_c_reg + COORD_WIDTH'(1);
                        dir_next = sorm_pkg::DIR_RIGHT;
                    end
                end
            endcase
        end

        if (restart)
        begin
            load_row_next = '0;
            load_col_next = '0;
            load_done_next = 1'b0;
            emitted_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= sorm_pkg::REG_WIDTH'(1);
            col_count_reg <= sorm_pkg::REG_WIDTH'(1);
            load_row_reg <= '0;
            load_col_reg <= '0;
            load_done_reg <= 1'b0;
            pos_r_reg <= '0;
            pos_c_reg <= '0;
            top_reg <= '0;
            bottom_reg <= '0;
            left_reg <= '0;
            right_reg <= '0;
            dir_reg <= sorm_pkg::DIR_RIGHT;
            emitted_reg <= '0;
            resp_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == sorm_pkg::CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == sorm_pkg::CFG_COL_COUNT)
            begin
                col_count_reg <= cfg_data;
            end
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            load_done_reg <= load_done_next;
            pos_r_reg <= pos_r_next;
            pos_c_reg <= pos_c_next;
            top_reg <= top_next;
            bottom_reg <= bottom_next;
            left_reg <= left_next;
            right_reg <= right_next;
            dir_reg <= dir_next;
            emitted_reg <= emitted_next;
            resp_reg <= resp_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_resp_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        resp_reg.valid |-> $past(is_emit))
        else $error("Response strobe without an emit transfer.");

    a_emitted_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        load_done_reg |-> (emitted_reg <= total))
        else $error("More elements emitted than the matrix holds.");

    a_walk_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (load_done_reg && emitted_reg != total) |->
            (DIM_WIDTH'(pos_r_reg) < rows && DIM_WIDTH'(pos_c_reg) < cols))
        else $error("Spiral position left the matrix.");

    a_no_read_before_full: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (load_done_reg && !wr_en))
        else $error("Matrix read before loading completed.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/spiral_order_matrix_reader.sv =====
// Top level of the spiral order matrix reader.
// Connects the load and walk sequencer to the matrix memory.
// Depends on sorm_pkg, sorm_walk and sorm_store.
//
// Usage: set row_count (index 0) and col_count (index 1) on the write port,
// then issue load commands carrying the elements in row-major order, then
// emit commands. A command transfer happens at a clock edge with start high
// and busy low; busy stays low, so a command can be issued every cycle.
// A load produces no result. Each emit produces one result in the cycle after
// its transfer, shown for one cycle with result_valid high: the element at
// the next clockwise spiral position, with last_element set on the final one.
// An emit before the matrix is full or after the walk has ended returns
// status 1 with a zero value. The rate is one command per cycle. A write to
// either size register restarts loading and the walk. Reset sets both sizes to
// one and clears the load and walk state; memory contents are kept. The
// receiver cannot stall, so results must be taken when they are shown.
`default_nettype none

module spiral_order_matrix_reader #(
    parameter int MAX_DIM = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [sorm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [sorm_pkg::REG_WIDTH-1:0]       cfg_data,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire sorm_pkg::in_item_t                   item,
    output logic                                      result_valid,
    output sorm_pkg::out_item_t                       result
);

    localparam int COORD_WIDTH = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  wr_en, rd_en;
    logic [ADDR_WIDTH-1:0] wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;
    sorm_pkg::resp_ctrl_t  resp;

    assign busy = 1'b0;
    assign wr_data = DATA_WIDTH'($unsigned(item.element_value));

    sorm_walk #(
        .MAX_DIM     (MAX_DIM),
        .COORD_WIDTH (COORD_WIDTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (start && !busy),
        .cmd       (item.command),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .resp      (resp)
    );

    sorm_store #(
        .DEPTH      (DEPTH),
        .ADDR_WIDTH (ADDR_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign result_valid = resp.valid;
    assign result.out_value = resp.err ? '0 : sorm_pkg::FIELD_WIDTH'(rd_data);
    assign result.last_element = resp.last;
    assign result.status = resp.err ? sorm_pkg::STATUS_ERR : sorm_pkg::STATUS_OK;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for spiral_order_matrix_reader: loads matrices of many sizes and checks the
// spiral walk, the last flag and the error status against a shadow model kept here.
// Depends on sorm_pkg and the RTL of the block; needs no other file.
module tb;

    localparam int DIM_MAX = 64;
    localparam int STORE_DEPTH = DIM_MAX * DIM_MAX;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [sorm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [sorm_pkg::REG_WIDTH-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    sorm_pkg::in_item_t item = '0;
    logic result_valid;
    sorm_pkg::out_item_t result;

    logic [sorm_pkg::REG_WIDTH-1:0] row_reg = sorm_pkg::REG_WIDTH'(1);
    logic [sorm_pkg::REG_WIDTH-1:0] col_reg = sorm_pkg::REG_WIDTH'(1);
    logic signed [sorm_pkg::FIELD_WIDTH-1:0] shadow_store [STORE_DEPTH];
    int loaded_n = 0;
    int emitted_n = 0;
    int ring_n = 0;
    sorm_pkg::dir_t side_n = sorm_pkg::DIR_RIGHT;
    int pos_n = 0;
    sorm_pkg::out_item_t spiral_outputs_due [$];
    sorm_pkg::out_item_t oldest;

    int fails = 0;
    int items_done = 0;
    int cycle_count = 0;
    int burst_left = 0;

    spiral_order_matrix_reader #(
        .MAX_DIM(DIM_MAX),
        .DATA_WIDTH(sorm_pkg::FIELD_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_dim(logic [sorm_pkg::REG_WIDTH-1:0] value);
        if (value == 0)
            return 1;
        if (value > DIM_MAX)
            return DIM_MAX;
        return int'(value);
    endfunction

    function automatic int side_len(int ring, sorm_pkg::dir_t side, int rows, int cols);
        int top_r;
        int bottom_r;
        int left_c;
        int right_c;
        top_r = ring;
        left_c = ring;
        bottom_r = rows - 1 - ring;
        right_c = cols - 1 - ring;
        if (bottom_r < top_r || right_c < left_c)
            return 0;
        case (side)
            sorm_pkg::DIR_RIGHT: return right_c - left_c + 1;
            sorm_pkg::DIR_DOWN:  return bottom_r - top_r;
            sorm_pkg::DIR_LEFT:  return (bottom_r > top_r) ? right_c - left_c : 0;
            default: return (bottom_r > top_r && right_c > left_c) ? bottom_r - top_r - 1 : 0;
        endcase
    endfunction

    // Advances the shadow walk by one element and returns the result that an emit produces.
    function automatic sorm_pkg::out_item_t next_spiral_element();
        int rows;
        int cols;
        int total;
        int r;
        int c;
        int far_r;
        int far_c;
        sorm_pkg::out_item_t res;
        rows = clamp_dim(row_reg);
        cols = clamp_dim(col_reg);
        total = rows * cols;
        res = '{out_value: '0, last_element: 1'b0, status: sorm_pkg::STATUS_ERR};
        if (loaded_n < total || emitted_n >= total)
            return res;
        for (int i = 0; i < 8 && pos_n >= side_len(ring_n, side_n, rows, cols); i++)
        begin
            pos_n = 0;
            if (side_n == sorm_pkg::DIR_UP)
            begin
                side_n = sorm_pkg::DIR_RIGHT;
                ring_n = (ring_n + 1) % DIM_MAX;
            end
            else
            begin
                side_n = sorm_pkg::dir_t'(side_n + 1);
            end
        end
        far_r = rows - 1 - ring_n;
        far_c = cols - 1 - ring_n;
        case (side_n)
            sorm_pkg::DIR_RIGHT:
            begin
                r = ring_n;
                c = ring_n + pos_n;
            end
            sorm_pkg::DIR_DOWN:
            begin
                r = ring_n + 1 + pos_n;
                c = far_c;
            end
            sorm_pkg::DIR_LEFT:
            begin
                r = far_r;
                c = far_c - 1 - pos_n;
            end
            default:
            begin
                r = far_r - 1 - pos_n;
                c = ring_n;
            end
        endcase
        if (r < 0)
            r = 0;
        if (c < 0)
            c = 0;
        pos_n++;
        emitted_n++;
        res.out_value = shadow_store[(r * DIM_MAX + c) % STORE_DEPTH];
        res.last_element = (emitted_n == total);
        res.status = sorm_pkg::STATUS_OK;
        return res;
    endfunction

    function automatic logic signed [sorm_pkg::FIELD_WIDTH-1:0] random_element();
        return $signed($urandom);
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        fails++;
    endtask

    // Transfers and size register writes update the shadow state at the edge that takes them.
    always @(posedge clk)
    begin : shadow_monitor
        int cols;
        int total;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (spiral_outputs_due.size() == 0)
                begin
                    $error("unexpected result: out_value %0d, last_element %0d, status %0d",
                           result.out_value, result.last_element, result.status);
                    fails++;
                end
                else
                begin
                    oldest = spiral_outputs_due.pop_front();
                    if (result.out_value !== oldest.out_value)
                        report_mismatch("out_value", oldest.out_value, result.out_value);
                    if (result.last_element !== oldest.last_element)
                        report_mismatch("last_element", oldest.last_element, result.last_element);
                    if (result.status !== oldest.status)
                        report_mismatch("status", oldest.status, result.status);
                end
            end
            if (cfg_write && (cfg_index == sorm_pkg::CFG_ROW_COUNT ||
                              cfg_index == sorm_pkg::CFG_COL_COUNT))
            begin
                if (cfg_index == sorm_pkg::CFG_ROW_COUNT)
                    row_reg = cfg_data;
                else
                    col_reg = cfg_data;
                loaded_n = 0;
                emitted_n = 0;
                ring_n = 0;
                side_n = sorm_pkg::DIR_RIGHT;
                pos_n = 0;
            end
            if (start && !busy)
            begin
                items_done++;
                cols = clamp_dim(col_reg);
                total = clamp_dim(row_reg) * cols;
                if (item.command == sorm_pkg::CMD_EMIT)
                begin
                    spiral_outputs_due.push_back(next_spiral_element());
                end
                else if (loaded_n < total)
                begin
                    shadow_store[(loaded_n / cols) * DIM_MAX + loaded_n % cols] =
                        item.element_value;
                    loaded_n++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The sender works in bursts; start is dropped in the gap between bursts.
    task automatic send_item(sorm_pkg::cmd_t cmd, logic signed [sorm_pkg::FIELD_WIDTH-1:0] value);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        item <= '{command: cmd, element_value: value};
        do @(posedge clk); while (busy);
    endtask

    task automatic load_elements(int count);
        repeat (count) send_item(sorm_pkg::CMD_LOAD, random_element());
    endtask

    task automatic emit_elements(int count);
        repeat (count) send_item(sorm_pkg::CMD_EMIT, '0);
    endtask

    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (spiral_outputs_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_size(logic [sorm_pkg::REG_WIDTH-1:0] rows,
                            logic [sorm_pkg::REG_WIDTH-1:0] cols);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= sorm_pkg::CFG_ROW_COUNT;
        cfg_data <= rows;
        @(posedge clk);
        cfg_index <= sorm_pkg::CFG_COL_COUNT;
        cfg_data <= cols;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(sorm_pkg::CMD_EMIT, '0);
        send_item(sorm_pkg::CMD_LOAD, 32'sh8000_0000);
        send_item(sorm_pkg::CMD_LOAD, 32'sh7FFF_FFFF);
        send_item(sorm_pkg::CMD_EMIT, '0);
        send_item(sorm_pkg::CMD_EMIT, '0);
    endtask

    task automatic test_single_row();
        set_size(0, 3);
        send_item(sorm_pkg::CMD_LOAD, 32'sh7FFF_FFFF);
        send_item(sorm_pkg::CMD_LOAD, 32'sh0000_0000);
        send_item(sorm_pkg::CMD_LOAD, -32'sd1);
        emit_elements(4);
    endtask

    task automatic test_single_column();
        set_size(3, 0);
        send_item(sorm_pkg::CMD_LOAD, 32'sh5555_5555);
        send_item(sorm_pkg::CMD_EMIT, '0);
        send_item(sorm_pkg::CMD_LOAD, 32'shAAAA_AAAA);
        send_item(sorm_pkg::CMD_LOAD, 32'sh8000_0000);
        emit_elements(4);
    endtask

    task automatic test_oversized_rows();
        set_size(127, 2);
        load_elements(DIM_MAX * 2);
        emit_elements(DIM_MAX * 2 + 1);
    endtask

    task automatic run_random_phase();
        int rows;
        int cols;
        int total;
        int style;
        rows = $urandom_range(1, 8);
        cols = $urandom_range(1, 8);
        case ($urandom_range(0, 19))
            0:
            begin
                rows = $urandom_range(9, 64);
                cols = $urandom_range(1, 3);
            end
            1:
            begin
                rows = $urandom_range(1, 3);
                cols = $urandom_range(9, 64);
            end
            2: rows = 0;
            3:
            begin
                rows = $urandom_range(0, 2);
                cols = $urandom_range(65, 127);
            end
            default: ;
        endcase
        set_size(sorm_pkg::REG_WIDTH'(rows), sorm_pkg::REG_WIDTH'(cols));
        total = clamp_dim(sorm_pkg::REG_WIDTH'(rows)) * clamp_dim(sorm_pkg::REG_WIDTH'(cols));
        style = $urandom_range(0, 9);
        if (style <= 6)
        begin
            for (int i = 0; i < total; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(sorm_pkg::CMD_EMIT, '0);
                send_item(sorm_pkg::CMD_LOAD, random_element());
            end
            if ($urandom_range(0, 3) == 0)
                send_item(sorm_pkg::CMD_LOAD, random_element());
            emit_elements(total + $urandom_range(0, 2));
        end
        else if (style == 7)
        begin
            repeat (2 * total + $urandom_range(0, 4))
                send_item($urandom_range(0, 1) ? sorm_pkg::CMD_EMIT : sorm_pkg::CMD_LOAD,
                          random_element());
        end
        else if (style == 8)
        begin
            load_elements($urandom_range(0, total - 1));
            emit_elements($urandom_range(1, 3));
        end
        else
        begin
            load_elements(total);
            emit_elements($urandom_range(0, total));
        end
    endtask

    task automatic test_random_phases();
        int goal;
        goal = items_done + RANDOM_ITEMS;
        while (items_done < goal)
            run_random_phase();
    endtask

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_single_row();
        test_single_column();
        test_oversized_rows();
        test_random_phases();
        drain();
        repeat (4) @(posedge clk);
        if (fails == 0 && spiral_outputs_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
